// ===== hw/rtl/wdpt_pkg.sv =====
`default_nettype none

package wdpt_pkg;

    localparam int DIST_W     = 14;
    localparam int RATE_W     = 12;
    localparam int TIME_W     = 32;
    localparam int POS_W      = 17;
    localparam int CNT_W      = 16;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_HALF     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_OFFSET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_ALPHA   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTERF_THRESH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_THRESH    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_TOLERANCE = 3'd7;

    localparam logic [TIME_W-1:0] TIMEOUT_MS         = 32'd500;
    localparam logic [CNT_W-1:0]  INTERFERENCE_LEVEL = 16'd3;
    localparam logic [CNT_W-1:0]  CNT_MAX            = 16'hFFFF;
    localparam logic [8:0]        ALPHA_ONE          = 9'd256;

    typedef struct packed {
        logic [11:0] field_half;
        logic [9:0]  sensor_offset;
        logic [13:0] min_valid;
        logic [13:0] max_valid;
        logic [8:0]  smooth_alpha;
        logic [11:0] interference_threshold;
        logic [10:0] turn_rate_threshold;
        logic [11:0] wall_tolerance;
    } wdpt_cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]        now_ms;
        logic signed [RATE_W-1:0] turn_rate;
        logic [DIST_W-1:0]        right_dist;
        logic [DIST_W-1:0]        left_dist;
        logic [DIST_W-1:0]        back_dist;
        logic [DIST_W-1:0]        front_dist;
    } wdpt_sample_t;

    typedef struct packed {
        logic                    interference;
        logic                    fix_ok;
        logic                    y_valid;
        logic                    x_valid;
        logic signed [POS_W-1:0] y_pos;
        logic signed [POS_W-1:0] x_pos;
    } wdpt_result_t;

    // clamp a wide position to the 17-bit range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [20:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 21'sd65535) begin
            r = 17'sh0FFFF;
        end else if (v < -21'sd65536) begin
            r = 17'sh10000;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wdpt_cfg_regs.sv =====
`default_nettype none

module wdpt_cfg_regs
    import wdpt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output      wdpt_cfg_t             cfg
);

    wdpt_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_half             <= 12'd1825;
            cfg_reg.sensor_offset          <= 10'd100;
            cfg_reg.min_valid              <= 14'd20;
            cfg_reg.max_valid              <= 14'd2000;
            cfg_reg.smooth_alpha           <= 9'd77;
            cfg_reg.interference_threshold <= 12'd200;
            cfg_reg.turn_rate_threshold    <= 11'd20;
            cfg_reg.wall_tolerance         <= 12'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FIELD_HALF:     cfg_reg.field_half             <= cfg_data[11:0];
                REG_SENSOR_OFFSET:  cfg_reg.sensor_offset          <= cfg_data[9:0];
                REG_MIN_VALID:      cfg_reg.min_valid              <= cfg_data[13:0];
                REG_MAX_VALID:      cfg_reg.max_valid              <= cfg_data[13:0];
                REG_SMOOTH_ALPHA:   cfg_reg.smooth_alpha           <= cfg_data[8:0];
                REG_INTERF_THRESH:  cfg_reg.interference_threshold <= cfg_data[11:0];
                REG_TURN_THRESH:    cfg_reg.turn_rate_threshold    <= cfg_data[10:0];
                REG_WALL_TOLERANCE: cfg_reg.wall_tolerance         <= cfg_data[11:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/wdpt_smooth.sv =====
`default_nettype none

// est = floor((a*fresh + (256-a)*old + 128) / 256), folded into a*(fresh-old) + 256*old
module wdpt_smooth
    import wdpt_pkg::*;
(
    input  wire logic signed [17:0]      fresh,
    input  wire logic signed [POS_W-1:0] old,
    input  wire logic [8:0]              alpha,
    output      logic signed [POS_W-1:0] est
);

    logic [8:0]         alpha_eff;
    logic signed [9:0]  alpha_s;
    logic signed [18:0] diff;
    logic signed [28:0] prod;
    logic signed [29:0] sum;

    always_comb
    begin
        alpha_eff = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
        alpha_s   = $signed({1'b0, alpha_eff});
        diff      = $signed({fresh[17], fresh}) - $signed({{2{old[POS_W-1]}}, old});
        prod      = diff * alpha_s;
        sum       = $signed({prod[28], prod})
                  + $signed({{5{old[POS_W-1]}}, old, 8'd0})
                  + 30'sd128;
        est       = sat_pos(sum[28:8]);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wdpt_core.sv =====
`default_nettype none

module wdpt_core
    import wdpt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire wdpt_sample_t sample,
    input  wire wdpt_cfg_t    cfg,
    output      wdpt_result_t res
);

    // tracker state
    logic signed [POS_W-1:0] x_est_reg, x_est_next;
    logic signed [POS_W-1:0] y_est_reg, y_est_next;
    logic                    x_trust_reg, x_trust_next;
    logic                    y_trust_reg, y_trust_next;
    logic [TIME_W-1:0]       last_time_reg, last_time_next;
    logic [DIST_W-1:0]       bw_dist_reg, bw_dist_next;
    logic                    bw_valid_reg, bw_valid_next;
    logic [DIST_W-1:0]       prev_back_reg, prev_back_next;
    logic [DIST_W-1:0]       prev_left_reg, prev_left_next;
    logic [DIST_W-1:0]       prev_right_reg, prev_right_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    logic                    vf, vb, vl, vr, any_valid;
    logic [TIME_W-1:0]       elapsed;
    logic                    timeout;
    logic [RATE_W-1:0]       rate_bits, rate_mag;
    logic                    turning;
    logic [14:0]             bw_diff, bw_mag;
    logic                    bw_take;
    logic [DIST_W-1:0]       bw_dist_upd;
    logic                    bw_valid_upd;
    logic [14:0]             width, expect_w;
    logic [15:0]             w_diff, w_mag;
    logic [14:0]             b_diff, b_mag;
    logic [16:0]             b_mag4, thr5;
    logic                    susp_w, susp_b, suspicious;
    logic [CNT_W-1:0]        cnt_upd;
    logic                    intf_upd;
    logic signed [15:0]      yb_mm;
    logic signed [POS_W-1:0] y_back;
    logic signed [14:0]      dx, dy;
    logic signed [17:0]      fresh_x, fresh_y;
    logic signed [POS_W-1:0] x_smooth, y_smooth;
    logic                    fix;

    always_comb
    begin
        vf = sample.front_dist >= cfg.min_valid && sample.front_dist <= cfg.max_valid;
        vb = sample.back_dist  >= cfg.min_valid && sample.back_dist  <= cfg.max_valid;
        vl = sample.left_dist  >= cfg.min_valid && sample.left_dist  <= cfg.max_valid;
        vr = sample.right_dist >= cfg.min_valid && sample.right_dist <= cfg.max_valid;
        any_valid = vf || vb || vl || vr;

        last_time_next = any_valid ? sample.now_ms : last_time_reg;
        elapsed        = sample.now_ms - last_time_next;
        timeout        = elapsed > TIMEOUT_MS;

        rate_bits = sample.turn_rate;
        rate_mag  = rate_bits[RATE_W-1] ? (~rate_bits + 12'd1) : rate_bits;
        turning   = rate_mag > {1'b0, cfg.turn_rate_threshold};

        // back-wall reference follows readings close to it
        bw_diff      = {1'b0, sample.back_dist} - {1'b0, bw_dist_reg};
        bw_mag       = bw_diff[14] ? (~bw_diff + 15'd1) : bw_diff;
        bw_take      = vb && (!bw_valid_reg || bw_mag < {3'b0, cfg.wall_tolerance});
        bw_dist_upd  = bw_take ? sample.back_dist : bw_dist_reg;
        bw_valid_upd = bw_take || bw_valid_reg;

        // sudden change of side-to-side width
        width    = {1'b0, sample.left_dist} + {1'b0, sample.right_dist};
        expect_w = bw_valid_upd ? {2'b0, cfg.field_half, 1'b0}
                                : {1'b0, prev_left_reg} + {1'b0, prev_right_reg};
        w_diff   = {1'b0, width} - {1'b0, expect_w};
        w_mag    = w_diff[15] ? (~w_diff + 16'd1) : w_diff;
        susp_w   = vl && vr && !turning && (w_mag > {4'b0, cfg.interference_threshold});

        // sudden back jump while turning, 4*delta > 5*thr
        b_diff = {1'b0, sample.back_dist} - {1'b0, prev_back_reg};
        b_mag  = b_diff[14] ? (~b_diff + 15'd1) : b_diff;
        b_mag4 = {b_mag, 2'b00};
        thr5   = {3'b0, cfg.interference_threshold, 2'b00}
               + {5'b0, cfg.interference_threshold};
        susp_b = turning && vb && (prev_back_reg != '0) && (b_mag4 > thr5);

        suspicious = susp_w || susp_b;
        if (suspicious)
        begin
            cnt_upd = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 16'd1;
        end
        else
        begin
            cnt_upd = (cnt_reg == '0) ? cnt_reg : cnt_reg - 16'd1;
        end
        intf_upd = cnt_upd >= INTERFERENCE_LEVEL;

        // back-only Y in mm, then 1/16 mm
        yb_mm  = $signed({2'b0, sample.back_dist}) + $signed({6'b0, cfg.sensor_offset})
               - $signed({4'b0, cfg.field_half});
        y_back = sat_pos($signed({yb_mm[15], yb_mm, 4'b0000}));

        // opposite-pair averages reduce to a plain difference
        dx      = $signed({1'b0, sample.left_dist}) - $signed({1'b0, sample.right_dist});
        dy      = $signed({1'b0, sample.back_dist}) - $signed({1'b0, sample.front_dist});
        fresh_x = $signed({dx, 3'b000});
        fresh_y = $signed({dy, 3'b000});
    end

    wdpt_smooth u_smooth_x (
        .fresh (fresh_x),
        .old   (x_est_reg),
        .alpha (cfg.smooth_alpha),
        .est   (x_smooth)
    );

    wdpt_smooth u_smooth_y (
        .fresh (fresh_y),
        .old   (y_est_reg),
        .alpha (cfg.smooth_alpha),
        .est   (y_smooth)
    );

    always_comb
    begin
        x_est_next      = x_est_reg;
        y_est_next      = y_est_reg;
        x_trust_next    = x_trust_reg;
        y_trust_next    = y_trust_reg;
        bw_dist_next    = bw_dist_reg;
        bw_valid_next   = bw_valid_reg;
        prev_back_next  = prev_back_reg;
        prev_left_next  = prev_left_reg;
        prev_right_next = prev_right_reg;
        cnt_next        = cnt_reg;
        fix             = 1'b0;

        if (timeout)
        begin
            x_trust_next = 1'b0;
            y_trust_next = 1'b0;
        end
        else
        begin
            bw_dist_next    = bw_dist_upd;
            bw_valid_next   = bw_valid_upd;
            cnt_next        = cnt_upd;
            prev_back_next  = vb ? sample.back_dist  : prev_back_reg;
            prev_left_next  = vl ? sample.left_dist  : prev_left_reg;
            prev_right_next = vr ? sample.right_dist : prev_right_reg;

            if (intf_upd || turning)
            begin
                if (vb && bw_valid_upd)
                begin
                    y_est_next   = y_back;
                    y_trust_next = 1'b1;
                end
                else
                begin
                    y_trust_next = 1'b0;
                end
                if (turning)
                begin
                    x_trust_next = 1'b0;
                end
                fix = y_trust_next;
            end
            else
            begin
                if (vl && vr)
                begin
                    x_est_next   = x_smooth;
                    x_trust_next = 1'b1;
                end
                else
                begin
                    x_trust_next = 1'b0;
                end
                if (vf && vb)
                begin
                    y_est_next   = y_smooth;
                    y_trust_next = 1'b1;
                end
                else
                begin
                    y_trust_next = 1'b0;
                end
                fix = (vl && vr) || (vf && vb);
            end
        end

        res.x_pos        = x_est_next;
        res.y_pos        = y_est_next;
        res.x_valid      = x_trust_next;
        res.y_valid      = y_trust_next;
        res.fix_ok       = fix;
        res.interference = cnt_next >= INTERFERENCE_LEVEL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_est_reg      <= '0;
            y_est_reg      <= '0;
            x_trust_reg    <= 1'b0;
            y_trust_reg    <= 1'b0;
            last_time_reg  <= '0;
            bw_dist_reg    <= '0;
            bw_valid_reg   <= 1'b0;
            prev_back_reg  <= '0;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            cnt_reg        <= '0;
        end
        else if (step)
        begin
            x_est_reg      <= x_est_next;
            y_est_reg      <= y_est_next;
            x_trust_reg    <= x_trust_next;
            y_trust_reg    <= y_trust_next;
            last_time_reg  <= last_time_next;
            bw_dist_reg    <= bw_dist_next;
            bw_valid_reg   <= bw_valid_next;
            prev_back_reg  <= prev_back_next;
            prev_left_reg  <= prev_left_next;
            prev_right_reg <= prev_right_next;
            cnt_reg        <= cnt_next;
        end
    end

    // counter moves by at most one per sample
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + 16'd1)
                 || (cnt_reg == $past(cnt_reg) - 16'd1))
        else $error("interference counter jumped");

    // a usable fix always leaves at least one trusted axis
    a_fix_trusted: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.fix_ok |-> res.x_valid || res.y_valid)
        else $error("fix without trusted axis");

    // once seeded the back-wall reference stays valid
    a_bw_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(bw_valid_reg))
        else $error("back-wall reference lost");

endmodule

`default_nettype wire

// ===== hw/rtl/wall_distance_position_tracker.sv =====
// wall-distance position tracker
// slave stream: one request per sample, s_tdata carries four wall distances,
// the signed gyro turn rate and the millisecond time stamp
// master stream: one request per sample with the X/Y estimate in 1/16 mm,
// the trust flags, the fix flag and the interference flag
// configuration: cfg_we / cfg_index / cfg_data write one of eight registers
// per clock; users write only with no sample in flight (block does not check)
// path: a request is taken into the input register, evaluated, and lands in
// the output register once that is free or being drained; m_tvalid then rises
// throughput: one sample per cycle unless m_tready stalls; the tracker state
// is updated in a single pass of logic between the input and output registers
// reset: all tracker state clears to zero and the registers take their
// defaults; both streams come up empty
// stall: while m_tready is low the output register holds its request and
// the input register keeps one more, then s_tready drops
`default_nettype none

module wall_distance_position_tracker
    import wdpt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // front_dist[13:0], back_dist[27:14], left_dist[41:28], right_dist[55:42],
    // turn_rate[67:56], now_ms[99:68], zero fill[103:100]
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // x_pos[16:0], y_pos[33:17], x_valid[34], y_valid[35], fix_ok[36],
    // interference[37], zero fill[39:38]
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    wdpt_cfg_t    cfg;
    wdpt_sample_t in_sample_reg;
    logic         in_valid_reg, in_valid_next;
    wdpt_result_t res;
    wdpt_result_t out_reg;
    logic         out_valid_reg, out_valid_next;
    logic         in_take;
    logic         advance;

    // sample moves on when the output register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    wdpt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register, payload only
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_sample_reg.front_dist <= s_tdata[13:0];
            in_sample_reg.back_dist  <= s_tdata[27:14];
            in_sample_reg.left_dist  <= s_tdata[41:28];
            in_sample_reg.right_dist <= s_tdata[55:42];
            in_sample_reg.turn_rate  <= $signed(s_tdata[67:56]);
            in_sample_reg.now_ms     <= s_tdata[99:68];
        end
    end

    // evaluation of one sample, state committed on advance
    wdpt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .sample (in_sample_reg),
        .cfg    (cfg),
        .res    (res)
    );

    // output register, payload only
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res;
        end
    end

    // handshake flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.interference, out_reg.fix_ok, out_reg.y_valid,
                       out_reg.x_valid, out_reg.y_pos, out_reg.x_pos};

    // an empty input register always takes a request
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    // an evaluated sample always shows on the master side next cycle
    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("result lost after evaluation");

    // a held sample is not dropped
    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("pending sample dropped");

endmodule

`default_nettype wire
